// ----- sv/rdbd_pkg.sv -----
// shared types, tables and functions of the one-round block descrambler
package rdbd_pkg;

  localparam int BLOCK_W   = 64;
  localparam int ET_W      = 8;
  localparam int DC_W      = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;
  localparam int EARLY_W   = 5;
  localparam int PHASE_W   = 5;
  localparam int SHUF_W    = 3;

  localparam logic [EARLY_W-1:0] EARLY_BLOCKS = 5'd20;
  localparam logic [SHUF_W-1:0]  SHUF_LAST    = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_TYPE  = 4'd0,
    CFG_DIGIT_COUNT = 4'd1
  } rdbd_cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_DECIPHER = 2'd0,
    ACT_SHUFFLE  = 2'd1,
    ACT_PASS     = 2'd2
  } rdbd_action_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    rdbd_action_t       action;
  } rdbd_item_t;

  localparam logic [7:0] INIT_PERM [64] = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7
  };

  localparam logic [7:0] FINAL_PERM [64] = '{
    8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25
  };

  localparam logic [7:0] P_PERM [32] = '{
    8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
    8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25
  };

  // paired s-boxes: high nibble for the even chunk, low nibble for the odd one
  localparam logic [7:0] SBOX_PAIR [4][64] = '{
    '{8'hef, 8'h03, 8'h41, 8'hfd, 8'hd8, 8'h74, 8'h1e, 8'h47,
      8'h26, 8'hef, 8'hfb, 8'h22, 8'hb3, 8'hd8, 8'h84, 8'h1e,
      8'h39, 8'hac, 8'ha7, 8'h60, 8'h62, 8'hc1, 8'hcd, 8'hba,
      8'h5c, 8'h96, 8'h90, 8'h59, 8'h05, 8'h3b, 8'h7a, 8'h85,
      8'h40, 8'hfd, 8'h1e, 8'hc8, 8'he7, 8'h8a, 8'h8b, 8'h21,
      8'hda, 8'h43, 8'h64, 8'h9f, 8'h2d, 8'h14, 8'hb1, 8'h72,
      8'hf5, 8'h5b, 8'hc8, 8'hb6, 8'h9c, 8'h37, 8'h76, 8'hec,
      8'h39, 8'ha0, 8'ha3, 8'h05, 8'h52, 8'h6e, 8'h0f, 8'hd9},
    '{8'ha7, 8'hdd, 8'h0d, 8'h78, 8'h9e, 8'h0b, 8'he3, 8'h95,
      8'h60, 8'h36, 8'h36, 8'h4f, 8'hf9, 8'h60, 8'h5a, 8'ha3,
      8'h11, 8'h24, 8'hd2, 8'h87, 8'hc8, 8'h52, 8'h75, 8'hec,
      8'hbb, 8'hc1, 8'h4c, 8'hba, 8'h24, 8'hfe, 8'h8f, 8'h19,
      8'hda, 8'h13, 8'h66, 8'haf, 8'h49, 8'hd0, 8'h90, 8'h06,
      8'h8c, 8'h6a, 8'hfb, 8'h91, 8'h37, 8'h8d, 8'h0d, 8'h78,
      8'hbf, 8'h49, 8'h11, 8'hf4, 8'h23, 8'he5, 8'hce, 8'h3b,
      8'h55, 8'hbc, 8'ha2, 8'h57, 8'he8, 8'h22, 8'h74, 8'hce},
    '{8'h2c, 8'hea, 8'hc1, 8'hbf, 8'h4a, 8'h24, 8'h1f, 8'hc2,
      8'h79, 8'h47, 8'ha2, 8'h7c, 8'hb6, 8'hd9, 8'h68, 8'h15,
      8'h80, 8'h56, 8'h5d, 8'h01, 8'h33, 8'hfd, 8'hf4, 8'hae,
      8'hde, 8'h30, 8'h07, 8'h9b, 8'he5, 8'h83, 8'h9b, 8'h68,
      8'h49, 8'hb4, 8'h2e, 8'h83, 8'h1f, 8'hc2, 8'hb5, 8'h7c,
      8'ha2, 8'h19, 8'hd8, 8'he5, 8'h7c, 8'h2f, 8'h83, 8'hda,
      8'hf7, 8'h6b, 8'h90, 8'hfe, 8'hc4, 8'h01, 8'h5a, 8'h97,
      8'h61, 8'ha6, 8'h3d, 8'h40, 8'h0b, 8'h58, 8'he6, 8'h3d},
    '{8'h4d, 8'hd1, 8'hb2, 8'h0f, 8'h28, 8'hbd, 8'he4, 8'h78,
      8'hf6, 8'h4a, 8'h0f, 8'h93, 8'h8b, 8'h17, 8'hd1, 8'ha4,
      8'h3a, 8'hec, 8'hc9, 8'h35, 8'h93, 8'h56, 8'h7e, 8'hcb,
      8'h55, 8'h20, 8'ha0, 8'hfe, 8'h6c, 8'h89, 8'h17, 8'h62,
      8'h17, 8'h62, 8'h4b, 8'hb1, 8'hb4, 8'hde, 8'hd1, 8'h87,
      8'hc9, 8'h14, 8'h3c, 8'h4a, 8'h7e, 8'ha8, 8'he2, 8'h7d,
      8'ha0, 8'h9f, 8'hf6, 8'h5c, 8'h6a, 8'h09, 8'h8d, 8'hf0,
      8'h0f, 8'he3, 8'h53, 8'h25, 8'h95, 8'h36, 8'h28, 8'hcb}
  };

  // table entry n names bit n counted from the msb, starting at 1
  function automatic logic [63:0] permute64(input logic [63:0] x, input logic [7:0] tab [64]);
    logic [63:0] r;
    logic [5:0]  src;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      src = tab[i][5:0] - 6'd1;
      r[63-i] = x[6'd63 - src];
    end
    return r;
  endfunction

  function automatic logic [31:0] p_permute(input logic [31:0] s);
    logic [31:0] f;
    logic [4:0]  src;
    f = '0;
    for (int k = 0; k < 32; k++) begin
      src = P_PERM[k][4:0] - 5'd1;
      f[31-k] = s[5'd31 - src];
    end
    return f;
  endfunction

  // one feistel round with zero key: left ^= P(S(E(right)))
  function automatic logic [63:0] one_round(input logic [63:0] x);
    logic [31:0] left;
    logic [31:0] right;
    logic [7:0]  b4, b5, b6, b7;
    logic [5:0]  e [8];
    logic [31:0] s;
    logic [7:0]  hi, lo;
    left  = x[63:32];
    right = x[31:0];
    b4 = right[31:24];
    b5 = right[23:16];
    b6 = right[15:8];
    b7 = right[7:0];
    e[0] = {b7[0], b4[7:3]};
    e[1] = {b4[4:0], b5[7]};
    e[2] = {b4[0], b5[7:3]};
    e[3] = {b5[4:0], b6[7]};
    e[4] = {b5[0], b6[7:3]};
    e[5] = {b6[4:0], b7[7]};
    e[6] = {b6[0], b7[7:3]};
    e[7] = {b7[4:0], b4[7]};
    s = '0;
    for (int k = 0; k < 4; k++) begin
      hi = SBOX_PAIR[k][e[2*k]];
      lo = SBOX_PAIR[k][e[2*k+1]];
      s[31-8*k -: 8] = {hi[7:4], lo[3:0]};
    end
    return {left ^ p_permute(s), right};
  endfunction

  function automatic logic [7:0] swap_last(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00:   r = 8'h2b;
      8'h2b:   r = 8'h00;
      8'h01:   r = 8'h68;
      8'h68:   r = 8'h01;
      8'h48:   r = 8'h77;
      8'h77:   r = 8'h48;
      8'h60:   r = 8'hff;
      8'hff:   r = 8'h60;
      8'h6c:   r = 8'h80;
      8'h80:   r = 8'h6c;
      8'hb9:   r = 8'hc0;
      8'hc0:   r = 8'hb9;
      8'heb:   r = 8'hfe;
      8'hfe:   r = 8'heb;
      default: r = a;
    endcase
    return r;
  endfunction

  // period 3..30 from the raw digit count
  function automatic logic [PHASE_W-1:0] period_of(input logic [DC_W-1:0] c);
    logic [PHASE_W-1:0] p;
    if (c < 4'd3)      p = 5'd3;
    else if (c < 4'd5) p = {1'b0, c} + 5'd1;
    else if (c < 4'd7) p = {1'b0, c} + 5'd9;
    else               p = {1'b0, c} + 5'd15;
    return p;
  endfunction

endpackage

// ----- sv/rdbd_if.sv -----
// valid/ready channel interfaces for input and result words
interface rdbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [rdbd_pkg::BLOCK_W-1:0] block_in;
  logic                         start_of_file;
  modport source (output valid, block_in, start_of_file, input ready);
  modport sink (input valid, block_in, start_of_file, output ready);
endinterface

interface rdbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [rdbd_pkg::BLOCK_W-1:0] block_out;
  logic [1:0]                   action_taken;
  modport source (output valid, block_out, action_taken, input ready);
  modport sink (input valid, block_out, action_taken, output ready);
endinterface

// ----- sv/rdbd_front.sv -----
// front end: config registers, per-file counters and action classification
module rdbd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rdbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdbd_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rdbd_pkg::BLOCK_W-1:0]   block_in,
  input  logic                           start_of_file,
  output logic                           q_valid,
  input  logic                           q_ready,
  output rdbd_pkg::rdbd_item_t           q_item
);

  logic [rdbd_pkg::ET_W-1:0]    entry_type_r;
  logic [rdbd_pkg::DC_W-1:0]    digit_count_r;
  logic [rdbd_pkg::EARLY_W-1:0] early_r, early_nxt, early_cur;
  logic [rdbd_pkg::PHASE_W-1:0] phase_r, phase_nxt, phase_cur, period;
  logic [rdbd_pkg::PHASE_W:0]   phase_inc;
  logic [rdbd_pkg::SHUF_W-1:0]  shuf_r, shuf_nxt, shuf_cur;
  logic                         accept, periodic, do_dec, do_shuf;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && in_ready;

  // start of file clears the counters before this word is classified
  assign early_cur = start_of_file ? '0 : early_r;
  assign phase_cur = start_of_file ? '0 : phase_r;
  assign shuf_cur  = start_of_file ? '0 : shuf_r;

  assign periodic = (entry_type_r == '0);
  assign do_dec   = (early_cur < rdbd_pkg::EARLY_BLOCKS) || (periodic && phase_cur == '0);
  assign do_shuf  = !do_dec && periodic && (shuf_cur == rdbd_pkg::SHUF_LAST);

  assign period    = rdbd_pkg::period_of(digit_count_r);
  assign phase_inc = {1'b0, phase_cur} + 1'b1;

  always_comb begin
    phase_nxt = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[rdbd_pkg::PHASE_W-1:0];
    early_nxt = (early_cur < rdbd_pkg::EARLY_BLOCKS) ? early_cur + 1'b1 : early_cur;
    if (do_dec) begin
      shuf_nxt = shuf_cur;
    end else if (do_shuf) begin
      shuf_nxt = rdbd_pkg::SHUF_W'(1);
    end else begin
      shuf_nxt = shuf_cur + 1'b1;
    end
  end

  always_comb begin
    q_item.block = block_in;
    if (do_dec) begin
      q_item.action = rdbd_pkg::ACT_DECIPHER;
    end else if (do_shuf) begin
      q_item.action = rdbd_pkg::ACT_SHUFFLE;
    end else begin
      q_item.action = rdbd_pkg::ACT_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_type_r  <= '0;
      digit_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rdbd_pkg::CFG_ENTRY_TYPE:  entry_type_r  <= cfg_data[rdbd_pkg::ET_W-1:0];
        rdbd_pkg::CFG_DIGIT_COUNT: digit_count_r <= cfg_data[rdbd_pkg::DC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      early_r <= '0;
      phase_r <= '0;
      shuf_r  <= '0;
    end else if (accept) begin
      early_r <= early_nxt;
      phase_r <= phase_nxt;
      shuf_r  <= shuf_nxt;
    end
  end

  a_early_sat: assert property (@(posedge clk) disable iff (!rst_n)
    early_r <= rdbd_pkg::EARLY_BLOCKS)
    else $error("early counter past saturation");

  // periods are at least three, so a fresh file always leaves phase one
  a_sof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && start_of_file |=> early_r == 5'd1 && phase_r == 5'd1)
    else $error("start of file did not restart the counters");

endmodule

// ----- sv/rdbd_queue.sv -----
// small word queue between classification and execution
module rdbd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rdbd_pkg::rdbd_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rdbd_pkg::rdbd_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  rdbd_pkg::rdbd_item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill did not follow a push");

endmodule

// ----- sv/rdbd_back.sv -----
// back end: decipher round, shuffle or pass, into the output register
module rdbd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  rdbd_pkg::rdbd_item_t         q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rdbd_pkg::BLOCK_W-1:0] out_block,
  output rdbd_pkg::rdbd_action_t       out_action
);

  logic                         out_valid_r;
  logic [rdbd_pkg::BLOCK_W-1:0] out_block_r, result;
  rdbd_pkg::rdbd_action_t       out_action_r;
  logic [rdbd_pkg::BLOCK_W-1:0] blk;
  logic                         take;

  assign blk     = q_item.block;
  assign q_ready = !out_valid_r || out_ready;
  assign take    = q_valid && q_ready;

  always_comb begin
    case (q_item.action)
      rdbd_pkg::ACT_DECIPHER: begin
        result = rdbd_pkg::permute64(
          rdbd_pkg::one_round(rdbd_pkg::permute64(blk, rdbd_pkg::INIT_PERM)),
          rdbd_pkg::FINAL_PERM);
      end
      // bytes 3,4,6,0,1,2,5 then the swapped last byte
      rdbd_pkg::ACT_SHUFFLE: begin
        result = {blk[39:32], blk[31:24], blk[15:8], blk[63:56],
                  blk[55:48], blk[47:40], blk[23:16], rdbd_pkg::swap_last(blk[7:0])};
      end
      default: result = blk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_block_r  <= result;
      out_action_r <= q_item.action;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_block  = out_block_r;
  assign out_action = out_action_r;

  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r && out_action_r == $past(q_item.action))
    else $error("taken word missing from output register");

endmodule

// ----- sv/reduced_des_block_descrambler_unit.sv -----
// top level of the one-round block descrambler
//
//   port       dir  payload                             handshake
//   in_ch      in   block_in[63:0], start_of_file       valid/ready
//   out_ch     out  block_out[63:0], action_taken[1:0]  valid/ready
//   cfg_*      in   cfg_index[3:0], cfg_data[7:0]       cfg_we, no back-pressure
//
// one word per cycle sustained while out_ch.ready holds; an accepted word passes through
// the queue, then the output register after the round logic, before it is offered on out_ch
// the counter update in the front end takes one word per cycle while the queue has room
// rst_n is synchronous; it clears the registers, counters, queue and output valid
// an output stall fills the output register, then the queue, then drops in_ch.ready
module reduced_des_block_descrambler_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rdbd_in_if.sink                        in_ch,
  rdbd_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rdbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdbd_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic                   fq_valid, fq_ready, qb_valid, qb_ready;
  rdbd_pkg::rdbd_item_t   fq_item, qb_item;
  rdbd_pkg::rdbd_action_t out_action;

  rdbd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .block_in      (in_ch.block_in),
    .start_of_file (in_ch.start_of_file),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_item        (fq_item)
  );

  rdbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  rdbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_block  (out_ch.block_out),
    .out_action (out_action)
  );

  assign out_ch.action_taken = out_action;

endmodule
